[rtl/pff_pkg.sv]
// Pareto front finder package: sizes, payload structs, lane and merge types, FSM states.
// Self-contained; imported by every module of the block.
`default_nettype none
package pff_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_OBJ    = 4;
    localparam int OBJ_W      = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SEL_W      = (MAX_OBJ > 1) ? $clog2(MAX_OBJ) : 1;
    localparam int NOBJ_W     = 3;
    localparam int FRONT_W    = 6;
    localparam logic [NOBJ_W-1:0] NOBJ_RESET = 3'd2;

    typedef logic signed [OBJ_W-1:0] t_obj;

    typedef struct packed {
        t_obj obj_0;
        t_obj obj_1;
        t_obj obj_2;
        t_obj obj_3;
        logic last_point;
    } t_in;

    typedef struct packed {
        logic [FRONT_W-1:0] front_index;
        logic               last_of_front;
        logic               overflow;
    } t_out;

    // One stored point: all objectives side by side, objective 0 in the low word.
    typedef logic [MAX_OBJ-1:0][OBJ_W-1:0] t_vec;

    // Per-objective compare of the current point against a stored one.
    typedef struct packed {
        logic cur_gt;
        logic st_gt;
    } t_lane_cmp;

    // Bit k: dominance over the first k+1 objectives.
    typedef struct packed {
        logic [MAX_OBJ-1:0] cur_dom;
        logic [MAX_OBJ-1:0] st_dom;
    } t_dom;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_SCAN
    } t_state;

endpackage
`default_nettype wire

[rtl/pff_lane.sv]
// Compare lane: signed compare of one objective of the current and a stored point.
// Depends on pff_pkg; result is registered.
`default_nettype none
module pff_lane (
    input  wire                i_clk,
    input  wire pff_pkg::t_obj i_cur,
    input  wire pff_pkg::t_obj i_st,
    output pff_pkg::t_lane_cmp o_cmp
);
    import pff_pkg::*;

    t_lane_cmp r_cmp;
    t_lane_cmp n_cmp;

    always_comb begin
        n_cmp.cur_gt = (i_cur > i_st);
        n_cmp.st_gt  = (i_st > i_cur);
    end

    always_ff @(posedge i_clk) begin
        r_cmp <= n_cmp;
    end

    assign o_cmp = r_cmp;

endmodule
`default_nettype wire

[rtl/pff_merge.sv]
// Merge stage: combines the lane compares into dominance in both directions
// for every prefix of active objectives. Depends on pff_pkg.
`default_nettype none
module pff_merge (
    input  wire pff_pkg::t_lane_cmp [pff_pkg::MAX_OBJ-1:0] i_cmp,
    output pff_pkg::t_dom                                   o_dom
);
    import pff_pkg::*;

    always_comb begin
        logic cur_ge;
        logic st_ge;
        logic cur_any;
        logic st_any;
        cur_ge  = 1'b1;
        st_ge   = 1'b1;
        cur_any = 1'b0;
        st_any  = 1'b0;
        for (int k = 0; k < MAX_OBJ; k++) begin
            cur_ge  = cur_ge & ~i_cmp[k].st_gt;
            st_ge   = st_ge & ~i_cmp[k].cur_gt;
            cur_any = cur_any | i_cmp[k].cur_gt;
            st_any  = st_any | i_cmp[k].st_gt;
            o_dom.cur_dom[k] = cur_ge & cur_any;
            o_dom.st_dom[k]  = st_ge & st_any;
        end
    end

endmodule
`default_nettype wire

[rtl/pareto_front_finder.sv]
// Pareto front finder: point store, sweep sequencer, objective lanes, mark memory, front scan.
// Busy stays high while a stored point is swept against the points already held: one stored
// point compared per cycle through the memory read port, then the compare pipeline empties.
// The point marked last adds a scan over the held points; the final result strobe rises in
// the same cycle that busy falls. The receiver cannot stall.
// Synchronous active-low reset clears count, overflow and state and sets two objectives.
`default_nettype none
module pareto_front_finder (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire pff_pkg::t_in          i_item,
    input  wire                        i_cfg_we,
    input  wire [pff_pkg::NOBJ_W-1:0]  i_cfg_wdata,
    output logic                       o_strobe,
    output pff_pkg::t_out              o_result
);
    import pff_pkg::*;

    t_state r_state, n_state;

    logic [NOBJ_W-1:0] r_nobj;
    logic [SEL_W-1:0]  r_sel;
    logic              r_last;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_lim;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_cur_idx;
    t_vec              r_cur;

    t_vec              r_mem [MAX_POINTS];
    t_vec              r_rd_data;
    logic              r_s1_vld;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s2_vld;
    logic [IDX_W-1:0]  r_s2_idx;

    // Mark memory: bit k set when the point is dominated over the first k+1 objectives.
    logic [MAX_OBJ-1:0] r_mark_mem [MAX_POINTS];
    logic [MAX_OBJ-1:0] r_mark_rd;
    logic [MAX_OBJ-1:0] r_s2_mark;
    logic [MAX_OBJ-1:0] r_cur_mark;
    logic               r_sc_vld;
    logic [IDX_W-1:0]   r_sc_idx;

    logic              r_pend_vld;
    logic [IDX_W-1:0]  r_pend_idx;
    logic              r_strobe;
    t_out              r_result;

    logic              w_accept;
    logic              w_store;
    logic              w_rd_en;
    logic              w_mark_commit;
    logic              w_scan_step;
    logic              w_scan_end;
    logic              w_member;
    t_vec              w_in_vec;
    logic [SEL_W-1:0]  w_sel;
    t_lane_cmp [MAX_OBJ-1:0] w_cmp;
    t_dom              w_dom;

    assign w_accept = start & ~busy;
    assign w_store  = w_accept & (r_cnt < CNT_W'(MAX_POINTS));
    assign w_in_vec = {i_item.obj_3, i_item.obj_2, i_item.obj_1, i_item.obj_0};

    // Saturate the objective count to 1..MAX_OBJ, then take it as a prefix select.
    always_comb begin
        if (r_nobj == '0) begin
            w_sel = '0;
        end else if (r_nobj > NOBJ_W'(MAX_OBJ)) begin
            w_sel = SEL_W'(MAX_OBJ - 1);
        end else begin
            w_sel = SEL_W'(r_nobj - 1'b1);
        end
    end

    // Point store: one write per stored point, one registered read per stored point compared.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_cnt[IDX_W-1:0]] <= w_in_vec;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_j[IDX_W-1:0]];
        end
    end

    // Marks: read alongside the stored point, carried through r_mark_rd and r_s2_mark, merged
    // and written back; the current point's marks are written once its sweep has drained.
    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_mark_mem[r_s2_idx] <= r_s2_mark | w_dom.cur_dom;
        end else if (w_mark_commit) begin
            r_mark_mem[r_cur_idx] <= r_cur_mark;
        end
        if (w_rd_en) begin
            r_mark_rd <= r_mark_mem[r_j[IDX_W-1:0]];
        end else if (w_scan_step) begin
            r_mark_rd <= r_mark_mem[r_i[IDX_W-1:0]];
        end
    end

    for (genvar g = 0; g < MAX_OBJ; g++) begin : g_lane
        pff_lane u_lane (
            .i_clk (i_clk),
            .i_cur (t_obj'(r_cur[g])),
            .i_st  (t_obj'(r_rd_data[g])),
            .o_cmp (w_cmp[g])
        );
    end

    pff_merge u_merge (
        .i_cmp (w_cmp),
        .o_dom (w_dom)
    );

    assign w_member = r_sc_vld & ~r_mark_rd[r_sel];

    always_comb begin
        n_state       = r_state;
        busy          = 1'b1;
        w_rd_en       = 1'b0;
        w_mark_commit = 1'b0;
        w_scan_step   = 1'b0;
        w_scan_end    = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (w_accept) begin
                    if (w_store) begin
                        n_state = S_SWEEP;
                    end else if (i_item.last_point) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SWEEP: begin
                if (r_j < r_lim) begin
                    w_rd_en = 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    w_mark_commit = 1'b1;
                    n_state       = r_last ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_i < r_cnt) begin
                    w_scan_step = 1'b1;
                end else if (!r_sc_vld) begin
                    w_scan_end = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nobj     <= NOBJ_RESET;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_cur_mark <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_sc_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
            r_last     <= 1'b0;
            r_sel      <= '0;
            r_j        <= '0;
            r_i        <= '0;
            r_lim      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_nobj <= i_cfg_wdata;
            end

            if (w_accept) begin
                r_last     <= i_item.last_point;
                r_sel      <= w_sel;
                r_j        <= '0;
                r_i        <= '0;
                r_pend_vld <= 1'b0;
                r_cur_mark <= '0;
                r_lim      <= r_cnt;
                if (w_store) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            // Advance the compare pipeline.
            r_s1_vld <= w_rd_en;
            r_s2_vld <= r_s1_vld;
            if (w_rd_en) begin
                r_j <= r_j + 1'b1;
            end

            if (r_s2_vld) begin
                r_cur_mark <= r_cur_mark | w_dom.st_dom;
            end

            // Hold one front member back so the final one can be flagged.
            r_sc_vld <= w_scan_step;
            r_strobe <= w_scan_end | (w_member & r_pend_vld);
            if (w_scan_step) begin
                r_i <= r_i + 1'b1;
            end
            if (w_member) begin
                r_pend_vld <= 1'b1;
            end
            if (w_scan_end) begin
                r_pend_vld <= 1'b0;
                r_cnt      <= '0;
                r_ovf      <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_cur     <= w_in_vec;
            r_cur_idx <= r_cnt[IDX_W-1:0];
        end
        r_s1_idx  <= r_j[IDX_W-1:0];
        r_s2_idx  <= r_s1_idx;
        r_s2_mark <= r_mark_rd;
        r_sc_idx  <= r_i[IDX_W-1:0];
        if (w_member) begin
            r_pend_idx <= r_sc_idx;
            r_result.front_index   <= FRONT_W'(r_pend_idx);
            r_result.last_of_front <= 1'b0;
            r_result.overflow      <= r_ovf;
        end
        if (w_scan_end) begin
            r_result.front_index   <= FRONT_W'(r_pend_idx);
            r_result.last_of_front <= 1'b1;
            r_result.overflow      <= r_ovf;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_last_isolated : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_front) |=> !o_strobe)
        else $error("front transaction follows the final index");

    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store size");

    a_pipe_in_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld || r_s2_vld) |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("compare pipeline busy outside sweep");

    a_scan_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt != '0))
        else $error("front scan over an empty set");
`endif

endmodule
`default_nettype wire

[tb/sv/pareto_front_finder_tb.sv]
`timescale 1ns / 100ps
// Testbench for pareto_front_finder: drives point sets through the start/busy port,
// predicts each front and checks every result strobe in order.
// Depends on pff_pkg and the pareto_front_finder RTL only.
module pareto_front_finder_tb;
    import pff_pkg::*;

    localparam int   SETTLE_CYCLES = 160;
    localparam int   STALL_LIMIT   = 5000;
    localparam t_obj OBJ_MIN       = 32'sh8000_0000;
    localparam t_obj OBJ_MAX       = 32'sh7fff_ffff;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    t_in                i_item      = '0;
    logic               i_cfg_we    = 1'b0;
    logic [NOBJ_W-1:0]  i_cfg_wdata = '0;
    logic               o_strobe;
    t_out               o_result;

    t_in   pending_points[$];
    t_out  expected_front[$];

    // predictor state: points of the open set, overflow, objective count register
    t_obj              held_pts[MAX_POINTS][MAX_OBJ];
    bit                held_beaten[MAX_POINTS];
    int                held_count;
    bit                set_overflow;
    logic [NOBJ_W-1:0] objective_reg;

    bit took;
    bit calm;
    int mismatches;
    int stall_cycles;
    int random_queued;

    always #2 i_clk = ~i_clk;

    pareto_front_finder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // b beats a when it is no worse in every active objective and better in one
    function automatic bit beats(int b, int a, int n);
        bit strict;
        strict = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (held_pts[b][k] < held_pts[a][k]) return 1'b0;
            if (held_pts[b][k] > held_pts[a][k]) strict = 1'b1;
        end
        return strict;
    endfunction

    function automatic void take_point(t_in it);
        int   n;
        int   last_idx;
        t_out r;
        if (held_count < MAX_POINTS) begin
            held_pts[held_count][0] = it.obj_0;
            held_pts[held_count][1] = it.obj_1;
            held_pts[held_count][2] = it.obj_2;
            held_pts[held_count][3] = it.obj_3;
            held_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!it.last_point) return;
        // count latched when the closing point arrives; zero means one, clamp at the top
        n = (objective_reg == 0) ? 1 : (objective_reg > MAX_OBJ) ? MAX_OBJ : int'(objective_reg);
        last_idx = 0;
        for (int i = 0; i < held_count; i++) begin
            held_beaten[i] = 1'b0;
            for (int j = 0; j < held_count; j++)
                if (j != i && beats(j, i, n)) held_beaten[i] = 1'b1;
            if (!held_beaten[i]) last_idx = i;
        end
        for (int i = 0; i < held_count; i++) begin
            if (held_beaten[i]) continue;
            r.front_index   = FRONT_W'(i);
            r.last_of_front = (i == last_idx);
            r.overflow      = set_overflow;
            expected_front  = {expected_front, r};
        end
        held_count   = 0;
        set_overflow = 1'b0;
    endfunction

    // monitor: results, accepted transactions, register writes, watchdog
    always @(posedge i_clk) begin
        t_out want;
        bit   moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            held_count    = 0;
            set_overflow  = 1'b0;
            objective_reg = NOBJ_RESET;
        end else begin
            if (o_strobe) begin
                moved = 1'b1;
                if (expected_front.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual index %0d",
                             $time, o_result.front_index);
                end else begin
                    want = expected_front.pop_front();
                    if (o_result.front_index !== want.front_index) begin
                        mismatches++;
                        $display("%0t front_index: expected %0d, actual %0d",
                                 $time, want.front_index, o_result.front_index);
                    end
                    if (o_result.last_of_front !== want.last_of_front) begin
                        mismatches++;
                        $display("%0t last_of_front: expected %0b, actual %0b",
                                 $time, want.last_of_front, o_result.last_of_front);
                    end
                    if (o_result.overflow !== want.overflow) begin
                        mismatches++;
                        $display("%0t overflow: expected %0b, actual %0b",
                                 $time, want.overflow, o_result.overflow);
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                took  = 1'b1;
                take_point(i_item);
            end
            if (i_cfg_we) objective_reg = i_cfg_wdata;
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver: hold the transaction until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            took = 1'b0;
            if (pending_points.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
                i_item <= pending_points.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic queue_point(t_obj a, t_obj b, t_obj c, t_obj d, bit last);
        t_in it;
        it.obj_0       = a;
        it.obj_1       = b;
        it.obj_2       = c;
        it.obj_3       = d;
        it.last_point  = last;
        pending_points = {pending_points, it};
    endtask

    function automatic t_obj rand_obj(bit narrow);
        int lvl;
        if (narrow) return t_obj'($urandom_range(3));
        case ($urandom_range(3))
            0: return t_obj'($urandom);
            1: begin
                lvl = $urandom_range(6);
                return t_obj'((lvl - 3) * 65536);
            end
            2: begin
                case ($urandom_range(3))
                    0: return OBJ_MIN;
                    1: return OBJ_MAX;
                    2: return t_obj'(0);
                    default: return t_obj'(-1);
                endcase
            end
            default: begin
                lvl = $urandom_range(7);
                return t_obj'(lvl - 4);
            end
        endcase
    endfunction

    task automatic queue_random_set(int len, bit close);
        bit narrow;
        narrow = bit'($urandom_range(1));
        for (int i = 0; i < len; i++)
            queue_point(rand_obj(narrow), rand_obj(narrow), rand_obj(narrow),
                        rand_obj(narrow), close && (i == len - 1));
        random_queued += len;
    endtask

    // wait for every transaction and result, then let the block go quiet
    task automatic settle();
        while (pending_points.size() != 0 || start || expected_front.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_objectives(logic [NOBJ_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int   sets;
        int   len;
        t_obj eq[MAX_OBJ];
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of two: extremes, ties in active objectives, one beaten point
        queue_point(OBJ_MIN, OBJ_MAX, rand_obj(0), rand_obj(0), 1'b0);
        queue_point(OBJ_MAX, OBJ_MIN, rand_obj(0), rand_obj(0), 1'b0);
        queue_point(0, 0, OBJ_MAX, OBJ_MIN, 1'b0);
        queue_point(0, 0, OBJ_MIN, OBJ_MAX, 1'b0);
        queue_point(-1, -1, 0, 0, 1'b1);
        queue_point(rand_obj(0), rand_obj(0), rand_obj(0), rand_obj(0), 1'b1);

        // zero objectives behaves as one
        settle();
        write_objectives(3'd0);
        queue_point(5, OBJ_MIN, OBJ_MIN, OBJ_MIN, 1'b0);
        queue_point(5, OBJ_MAX, 0, 0, 1'b0);
        queue_point(3, OBJ_MAX, OBJ_MAX, OBJ_MAX, 1'b1);

        // too many objectives saturates to four
        settle();
        write_objectives(3'd7);
        queue_point(1, 1, 1, OBJ_MAX, 1'b0);
        queue_point(1, 1, 1, 0, 1'b0);
        queue_point(1, 1, 1, OBJ_MAX, 1'b1);

        // count changed mid-set: the value at the closing point decides
        settle();
        write_objectives(3'd3);
        queue_point(2, 0, 0, 0, 1'b0);
        queue_point(2, 0, 9, 0, 1'b0);
        settle();
        write_objectives(3'd1);
        queue_point(1, 0, 0, 0, 1'b1);

        // identical points all survive
        settle();
        write_objectives(3'd4);
        foreach (eq[k]) eq[k] = t_obj'($urandom);
        for (int i = 0; i < 3; i++) queue_point(eq[0], eq[1], eq[2], eq[3], i == 2);

        // full store, a dropped point and a dropped closing point, sent with no idling
        settle();
        write_objectives(3'd2);
        calm = 1'b1;
        queue_random_set(MAX_POINTS + 2, 1'b1);

        for (int p = 0; random_queued < 135; p++) begin
            settle();
            calm = (p == 2 || p == 3);
            write_objectives(NOBJ_W'($urandom_range(7)));
            sets = $urandom_range(1, 4);
            for (int s = 0; s < sets; s++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                queue_random_set(len, 1'b1);
            end
            // leave a set open across the next register write
            if ($urandom_range(4) == 0) queue_random_set($urandom_range(1, 3), 1'b0);
        end
        calm = 1'b0;
        queue_random_set(1, 1'b1);

        settle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/pff_pkg.sv
rtl/pff_lane.sv
rtl/pff_merge.sv
rtl/pareto_front_finder.sv
tb/sv/pareto_front_finder_tb.sv
